>>> src/grwd_pkg.sv
`default_nettype none
package grwd_pkg;

   localparam int MAX_STEPS_DEF  = 8;
   localparam int CELL_SHIFT_DEF = 6;
   localparam int GRID_SIZE_DEF  = 8;

   localparam int FRAC_BITS    = 7;
   localparam int TRIG_SHIFT   = 14;
   localparam int CORDIC_STEPS = 15;
   localparam int CORDIC_START = 9949;
   localparam int MAP_STRIDE   = 8;
   localparam int QUEUE_DEPTH  = 2;

   localparam int ANGLE_W = 12;
   localparam int POS_W   = 16;
   localparam int DIST_W  = 17;
   localparam int MAP_W   = 64;
   localparam int TRIG_W  = 18;
   localparam int ZW      = 17;
   localparam int ITER_W  = 4;
   localparam int DEN_W   = 17;
   localparam int WIDE_W  = 24;
   localparam int NUM_W   = WIDE_W + TRIG_W;
   localparam int MAP_IDX_W = 6;

   localparam logic [ANGLE_W-1:0] ANG_ZERO    = 12'd0;
   localparam logic [ANGLE_W-1:0] ANG_QUARTER = 12'd1024;
   localparam logic [ANGLE_W-1:0] ANG_HALF    = 12'd2048;
   localparam logic [ANGLE_W-1:0] ANG_3QUART  = 12'd3072;

   localparam logic [DIST_W-1:0] DIST_MAX = 17'd131071;

   typedef struct packed {
      logic [POS_W-1:0]         px;
      logic [POS_W-1:0]         py;
      logic signed [TRIG_W-1:0] cos_v;
      logic signed [TRIG_W-1:0] sin_v;
      logic                     h_en;
      logic                     h_pos;
      logic                     v_en;
      logic                     v_pos;
   } ray_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_RUN,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_PASS,
      B_GAP,
      B_MUL,
      B_STARTA,
      B_DIVA,
      B_CHECK,
      B_DIVB,
      B_NEXT,
      B_OUT
   } back_state_type;

   function automatic logic signed [ZW-1:0] cordic_atan(input logic [ITER_W-1:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         4'd0: v = 17'sd8192;
         4'd1: v = 17'sd4836;
         4'd2: v = 17'sd2555;
         4'd3: v = 17'sd1297;
         4'd4: v = 17'sd651;
         4'd5: v = 17'sd326;
         4'd6: v = 17'sd163;
         4'd7: v = 17'sd81;
         4'd8: v = 17'sd41;
         4'd9: v = 17'sd20;
         4'd10: v = 17'sd10;
         4'd11: v = 17'sd5;
         4'd12: v = 17'sd3;
         4'd13: v = 17'sd1;
         4'd14: v = 17'sd1;
         default: v = 17'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> src/grwd_front.sv
`default_nettype none
module grwd_front (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire [grwd_pkg::ANGLE_W-1:0]   req_ray_angle,
   input  wire [grwd_pkg::POS_W-1:0]     req_player_x,
   input  wire [grwd_pkg::POS_W-1:0]     req_player_y,
   output logic                          out_valid,
   input  wire                           out_ready,
   output grwd_pkg::ray_type             out_ray
);
   import grwd_pkg::*;

   front_state_type          state_ff, state_in;
   logic [ANGLE_W-1:0]       ang_ff;
   logic [POS_W-1:0]         px_ff, py_ff;
   logic signed [TRIG_W-1:0] x_ff, y_ff;
   logic signed [ZW-1:0]     z_ff;
   logic                     flip_ff;
   logic [ITER_W-1:0]        iter_ff;

   logic signed [17:0]       a_ext;
   logic signed [17:0]       z_start;
   logic                     flip_start;
   logic signed [TRIG_W-1:0] xs, ys;
   logic signed [ZW-1:0]     atan_v;
   logic signed [TRIG_W-1:0] cos_out, sin_out;

   always_comb begin
      a_ext      = $signed({2'b00, req_ray_angle, 4'b0000});
      flip_start = (req_ray_angle >= ANG_QUARTER) && (req_ray_angle < ANG_3QUART);
      if (flip_start) begin
         z_start = a_ext - 18'sd32768;
      end else if (req_ray_angle >= ANG_3QUART) begin
         z_start = a_ext - 18'sd65536;
      end else begin
         z_start = a_ext;
      end
      xs      = x_ff >>> iter_ff;
      ys      = y_ff >>> iter_ff;
      atan_v  = cordic_atan(iter_ff);
      cos_out = flip_ff ? -x_ff : x_ff;
      sin_out = flip_ff ? -y_ff : y_ff;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) state_in = F_RUN;
         end
         F_RUN: begin
            if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (out_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == F_IDLE);
      out_valid     = (state_ff == F_PUSH);
      out_ray.px    = px_ff;
      out_ray.py    = py_ff;
      out_ray.cos_v = cos_out;
      out_ray.sin_v = sin_out;
      out_ray.h_en  = (ang_ff != ANG_ZERO) && (ang_ff != ANG_HALF) && (sin_out != '0);
      out_ray.h_pos = (ang_ff < ANG_HALF);
      out_ray.v_en  = (ang_ff != ANG_QUARTER) && (ang_ff != ANG_3QUART) && (cos_out != '0);
      out_ray.v_pos = !((ang_ff > ANG_QUARTER) && (ang_ff < ANG_3QUART));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE) begin
         ang_ff  <= req_ray_angle;
         px_ff   <= req_player_x;
         py_ff   <= req_player_y;
         flip_ff <= flip_start;
         x_ff    <= TRIG_W'(CORDIC_START);
         y_ff    <= '0;
         z_ff    <= z_start[ZW-1:0];
         iter_ff <= '0;
      end else if (state_ff == F_RUN) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_v;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_v;
         end
         iter_ff <= iter_ff + 1'b1;
      end
   end

endmodule
`default_nettype wire

>>> src/grwd_fifo.sv
`default_nettype none
module grwd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = grwd_pkg::QUEUE_DEPTH
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              in_valid,
   output logic             in_ready,
   input  wire [WIDTH-1:0]  in_data,
   output logic             out_valid,
   input  wire              out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

>>> src/grwd_div.sv
`default_nettype none
module grwd_div (
   input  wire                             clock,
   input  wire                             reset,
   input  wire grwd_pkg::div_req_type      req,
   output logic                            done,
   output logic [grwd_pkg::NUM_W-1:0]      quot,
   output logic                            rem_nz
);
   import grwd_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                 run_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [NUM_W-1:0]     num_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;
   logic                 fits;

   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      fits  = (trial >= {1'b0, den_ff});
      diff  = trial - {1'b0, den_ff};
   end

   assign done   = done_ff;
   assign quot   = num_ff;
   assign rem_nz = (rem_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (cnt_ff == CNT_W'(NUM_W - 1))) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         num_ff <= req.num;
         den_ff <= req.den;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (run_ff) begin
         rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         num_ff <= {num_ff[NUM_W-2:0], fits};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

endmodule
`default_nettype wire

>>> src/grwd_back.sv
`default_nettype none
module grwd_back #(
   parameter int MAX_STEPS  = grwd_pkg::MAX_STEPS_DEF,
   parameter int CELL_SHIFT = grwd_pkg::CELL_SHIFT_DEF,
   parameter int GRID_SIZE  = grwd_pkg::GRID_SIZE_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            in_valid,
   output logic                           in_ready,
   input  wire grwd_pkg::ray_type         in_ray,
   input  wire [grwd_pkg::MAP_W-1:0]      wall_map,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [grwd_pkg::DIST_W-1:0]    rsp_wall_distance,
   output logic                           rsp_vertical_hit,
   output logic                           rsp_hit_found
);
   import grwd_pkg::*;

   localparam int CELL_BITS = CELL_SHIFT + FRAC_BITS;
   localparam int STEP_W    = $clog2(MAX_STEPS + 1);
   localparam logic signed [WIDE_W-1:0] GRID_A = WIDE_W'(GRID_SIZE);
   localparam logic signed [NUM_W-1:0]  GRID_C = NUM_W'(GRID_SIZE);

   back_state_type           state_ff, state_in;
   ray_type                  ent_ff;
   logic                     pass_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [WIDE_W-1:0] line_ff;
   logic [WIDE_W-1:0]        gap_ff;
   logic signed [NUM_W-1:0]  prod_ff;
   logic signed [NUM_W-1:0]  across_ff;
   logic [NUM_W-1:0]         best_ff;
   logic                     found_ff, vert_ff;
   logic                     rsp_valid_ff;
   logic [DIST_W-1:0]        dist_ff;
   logic                     rvert_ff, rfound_ff;

   logic signed [WIDE_W-1:0] p_s, q_s, line_start, line_pos, gap_n, along_idx;
   logic                     pos, en;
   logic signed [TRIG_W-1:0] along_t, cross_t, den_s;
   logic [DEN_W-1:0]         den;
   logic signed [NUM_W-1:0]  prod_n, q_c, fdiv, across_idx;
   logic [NUM_W-1:0]         prod_mag;
   logic                     in_grid, wall;
   logic [2:0]               col, row;
   logic [MAP_IDX_W-1:0]     map_idx;
   logic                     last_step;
   div_req_type              dreq;
   logic                     ddone, drem_nz;
   logic [NUM_W-1:0]         dquot;

   grwd_div u_div (
      .clock  (clock),
      .reset  (reset),
      .req    (dreq),
      .done   (ddone),
      .quot   (dquot),
      .rem_nz (drem_nz)
   );

   always_comb begin
      p_s        = pass_ff ? WIDE_W'(ent_ff.px) : WIDE_W'(ent_ff.py);
      q_s        = pass_ff ? WIDE_W'(ent_ff.py) : WIDE_W'(ent_ff.px);
      pos        = pass_ff ? ent_ff.v_pos : ent_ff.h_pos;
      en         = pass_ff ? ent_ff.v_en : ent_ff.h_en;
      along_t    = pass_ff ? ent_ff.cos_v : ent_ff.sin_v;
      cross_t    = pass_ff ? ent_ff.sin_v : ent_ff.cos_v;
      den_s      = (along_t < 0) ? -along_t : along_t;
      den        = den_s[DEN_W-1:0];
      line_start = (p_s >>> CELL_BITS) + (pos ? WIDE_W'(1) : WIDE_W'(0));
      line_pos   = line_ff <<< CELL_BITS;
      gap_n      = pos ? (line_pos - p_s) : (p_s - line_pos);
      prod_n     = $signed(gap_ff) * cross_t;
      prod_mag   = (prod_ff < 0) ? NUM_W'(-prod_ff) : NUM_W'(prod_ff);
      q_c        = NUM_W'(q_s);
      fdiv       = (prod_ff < 0) ? -$signed(dquot + NUM_W'(drem_nz)) : $signed(dquot);
      across_idx = across_ff >>> CELL_BITS;
      along_idx  = pos ? line_ff : line_ff - WIDE_W'(1);
      in_grid    = (across_idx >= 0) && (across_idx < GRID_C) &&
                   (along_idx >= 0) && (along_idx < GRID_A);
      col        = pass_ff ? along_idx[2:0] : across_idx[2:0];
      row        = pass_ff ? across_idx[2:0] : along_idx[2:0];
      map_idx    = MAP_IDX_W'(col * MAP_STRIDE + row);
      wall       = in_grid && wall_map[map_idx];
      last_step  = (step_ff == STEP_W'(MAX_STEPS - 1));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (in_valid && !rsp_valid_ff) state_in = B_PASS;
         end
         B_PASS:   state_in = en ? B_GAP : B_NEXT;
         B_GAP:    state_in = B_MUL;
         B_MUL:    state_in = B_STARTA;
         B_STARTA: state_in = B_DIVA;
         B_DIVA: begin
            if (ddone) state_in = B_CHECK;
         end
         B_CHECK: begin
            if (wall) begin
               state_in = B_DIVB;
            end else if (last_step) begin
               state_in = B_NEXT;
            end else begin
               state_in = B_GAP;
            end
         end
         B_DIVB: begin
            if (ddone) state_in = B_NEXT;
         end
         B_NEXT:   state_in = pass_ff ? B_OUT : B_PASS;
         B_OUT:    state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   always_comb begin
      in_ready   = (state_ff == B_IDLE) && !rsp_valid_ff;
      dreq.den   = den;
      dreq.start = 1'b0;
      dreq.num   = prod_mag;
      case (state_ff)
         B_STARTA: dreq.start = 1'b1;
         B_CHECK: begin
            dreq.start = wall;
            dreq.num   = NUM_W'(gap_ff) << TRIG_SHIFT;
         end
         default: dreq.start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            ent_ff   <= in_ray;
            pass_ff  <= 1'b0;
            found_ff <= 1'b0;
            vert_ff  <= 1'b0;
            best_ff  <= '0;
         end
         B_PASS: begin
            line_ff <= line_start;
            step_ff <= '0;
         end
         B_GAP: gap_ff <= gap_n[WIDE_W-1:0];
         B_MUL: prod_ff <= prod_n;
         B_DIVA: begin
            if (ddone) across_ff <= q_c + fdiv;
         end
         B_CHECK: begin
            if (!wall) begin
               line_ff <= pos ? line_ff + WIDE_W'(1) : line_ff - WIDE_W'(1);
               step_ff <= step_ff + 1'b1;
            end
         end
         B_DIVB: begin
            if (ddone) begin
               if (!pass_ff) begin
                  best_ff  <= dquot;
                  found_ff <= 1'b1;
               end else if (!found_ff || (dquot < best_ff)) begin
                  best_ff  <= dquot;
                  found_ff <= 1'b1;
                  vert_ff  <= 1'b1;
               end
            end
         end
         B_NEXT: pass_ff <= 1'b1;
         B_OUT: begin
            if (!found_ff || (best_ff > NUM_W'(DIST_MAX))) begin
               dist_ff <= DIST_MAX;
            end else begin
               dist_ff <= best_ff[DIST_W-1:0];
            end
            rvert_ff  <= vert_ff;
            rfound_ff <= found_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_wall_distance = dist_ff;
   assign rsp_vertical_hit  = rvert_ff;
   assign rsp_hit_found     = rfound_ff;

endmodule
`default_nettype wire

>>> src/grid_ray_wall_distance.sv
`default_nettype none
// Casts one ray per item over an 8x8 wall bitmap and returns the distance to the
// nearest wall, whether that wall lies on a vertical grid line, and a hit flag.
// The front computes cos and sin with an iterative CORDIC and hands the ray to a
// two-item queue; the back walks the horizontal and then the vertical grid lines
// with one shared bit-serial divider. Each crossing visited costs one division
// and a hit one further division; a pass is skipped when the ray runs parallel
// to its lines, and each pass visits at most MAX_STEPS crossings.
// The front overlaps its CORDIC with the back. The wall map is written through
// the configuration port at any address with paddr[3] low and resets to an empty
// map; write it only while the block is idle, which the block does not enforce.
module grid_ray_wall_distance #(
   parameter int MAX_STEPS  = grwd_pkg::MAX_STEPS_DEF,
   parameter int CELL_SHIFT = grwd_pkg::CELL_SHIFT_DEF,
   parameter int GRID_SIZE  = grwd_pkg::GRID_SIZE_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [grwd_pkg::ANGLE_W-1:0]  req_ray_angle,
   input  wire [grwd_pkg::POS_W-1:0]    req_player_x,
   input  wire [grwd_pkg::POS_W-1:0]    req_player_y,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [grwd_pkg::DIST_W-1:0]  rsp_wall_distance,
   output logic                         rsp_vertical_hit,
   output logic                         rsp_hit_found,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire [3:0]                    paddr,
   input  wire [grwd_pkg::MAP_W-1:0]    pwdata,
   output logic [grwd_pkg::MAP_W-1:0]   prdata,
   output logic                         pready
);
   import grwd_pkg::*;

   logic [MAP_W-1:0] wall_map_ff;
   logic             map_sel;
   logic             f_valid, f_ready;
   ray_type          f_ray;
   logic             q_valid, q_ready;
   ray_type          q_ray;

   assign map_sel = (paddr[3] == 1'b0);
   assign pready  = 1'b1;
   assign prdata  = map_sel ? wall_map_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_map_ff <= '0;
      end else if (psel && penable && pwrite && map_sel) begin
         wall_map_ff <= pwdata;
      end
   end

   grwd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_ray_angle (req_ray_angle),
      .req_player_x  (req_player_x),
      .req_player_y  (req_player_y),
      .out_valid     (f_valid),
      .out_ready     (f_ready),
      .out_ray       (f_ray)
   );

   grwd_fifo #(
      .WIDTH ($bits(ray_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_ray),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_ray)
   );

   grwd_back #(
      .MAX_STEPS  (MAX_STEPS),
      .CELL_SHIFT (CELL_SHIFT),
      .GRID_SIZE  (GRID_SIZE)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (q_valid),
      .in_ready          (q_ready),
      .in_ray            (q_ray),
      .wall_map          (wall_map_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_wall_distance (rsp_wall_distance),
      .rsp_vertical_hit  (rsp_vertical_hit),
      .rsp_hit_found     (rsp_hit_found)
   );

   a_miss_saturates : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit_found) |-> (rsp_wall_distance == DIST_MAX && !rsp_vertical_hit))
      else $error("miss result without saturated distance");

   a_pop_output_free : assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |-> !rsp_valid)
      else $error("queue popped while a result is still held");

   a_front_push_room : assert property (@(posedge clock) disable iff (reset)
      (f_valid && f_ready) |=> q_valid)
      else $error("queue empty after a push");

endmodule
`default_nettype wire
